// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define WBS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define WBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/wbs_pkg.sv =====
// types, constants and helper functions for the weighted box suppression block
// no dependencies
package wbs_pkg;

    localparam int APB_ADDR_W   = 3;
    // wide enough for up to 64 held entries
    localparam int SUM_W        = 38;
    localparam int TOTAL_W      = 22;
    localparam int MUL_A_W      = 16;
    localparam int MUL_B_W      = 34;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;
    localparam int NUM_COORDS   = 16;
    localparam int RESULT_LIMIT = 32;
    localparam int RES_CNT_W    = 6;

    localparam logic [15:0]        THRESH_RESET = 16'd19661;
    localparam logic [MUL_B_W-1:0] EPS_Q32      = 34'd4295;
    localparam logic [APB_ADDR_W-3:0] REG_THRESH = 1'b0;

    typedef struct packed {
        logic        valid_req;
        logic [15:0] box_left;
        logic [15:0] box_top;
        logic [15:0] box_right;
        logic [15:0] box_bottom;
        logic [15:0] confidence;
        logic [63:0] points_a;
        logic [63:0] points_b;
        logic [63:0] points_c;
        logic        frame_end;
    } in_item_t;

    typedef struct packed {
        logic [15:0] merged_left;
        logic [15:0] merged_top;
        logic [15:0] merged_right;
        logic [15:0] merged_bottom;
        logic [15:0] lead_score;
        logic [63:0] merged_points_a;
        logic [63:0] merged_points_b;
        logic [63:0] merged_points_c;
        logic        overflowed;
        logic        none_found;
        logic        final_result;
    } out_item_t;

    // box packs left in the low bits, then top, right, bottom
    typedef struct packed {
        logic [63:0] box;
        logic [15:0] score;
        logic [63:0] pts_a;
        logic [63:0] pts_b;
        logic [63:0] pts_c;
    } entry_t;

    function automatic logic [15:0] fld(input logic [63:0] w, input logic [1:0] k);
        return w[16*k +: 16];
    endfunction

    function automatic logic [15:0] span(input logic [15:0] lo, input logic [15:0] hi);
        return (hi > lo) ? (hi - lo) : 16'd0;
    endfunction

    function automatic logic [15:0] max16(input logic [15:0] a, input logic [15:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [15:0] min16(input logic [15:0] a, input logic [15:0] b);
        return (a < b) ? a : b;
    endfunction

    // coordinate 0..3 is the box, 4..15 the keypoint coordinates
    function automatic logic [15:0] coord_of(input entry_t e, input logic [3:0] c);
        logic [3:0] cm;
        logic [15:0] v;
        cm = c - 4'd4;
        if (c < 4'd4) begin
            v = fld(e.box, c[1:0]);
        end else begin
            case (cm[3:2])
                2'd0:    v = fld(e.pts_a, cm[1:0]);
                2'd1:    v = fld(e.pts_b, cm[1:0]);
                default: v = fld(e.pts_c, cm[1:0]);
            endcase
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/wbs_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module wbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end
endmodule

// ===== hw/rtl/wbs_mul.sv =====
// shared multiplier with a registered product
// depends on wbs_pkg
module wbs_mul (
    input  logic                          aclk,
    input  logic [wbs_pkg::MUL_A_W-1:0]   mul_a,
    input  logic [wbs_pkg::MUL_B_W-1:0]   mul_b,
    output logic [wbs_pkg::PROD_W-1:0]    prod
);
    import wbs_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    assign prod = prod_reg;
endmodule

// ===== hw/rtl/wbs_div.sv =====
// restoring divider, one quotient bit a cycle, 16-bit quotient
// depends on wbs_pkg; dividend must be below divisor * 2^16
module wbs_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [wbs_pkg::SUM_W-1:0]    dividend,
    input  logic [wbs_pkg::TOTAL_W-1:0]  divisor,
    output logic                         done,
    output logic [15:0]                  quotient
);
    import wbs_pkg::*;

    logic [TOTAL_W-1:0] rem_reg, rem_next;
    logic [TOTAL_W-1:0] dvs_reg, dvs_next;
    logic [15:0]        quo_reg, quo_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [TOTAL_W:0]   trial;

    always_comb begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[15]};
        if (start) begin
            rem_next  = dividend[SUM_W-1:16];
            quo_next  = dividend[15:0];
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = TOTAL_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[14:0], 1'b1};
            end else begin
                rem_next = trial[TOTAL_W-1:0];
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ===== hw/rtl/weighted_box_suppression_top.sv =====
// Weighted box suppression: sorted candidate store and clustering sequencer.
// Input beats (s_*) carry at most one detection each (valid_req); the beat with
// frame_end set closes the frame. A detection is inserted by descending score
// into a ram, shifting one entry at a time through S_INS_STEP and S_INS_CMP.
// On frame_end the sequencer walks the store: each unsuppressed entry leads a
// cluster, later entries pass an IoU test through the shared multiplier and
// members are accumulated one coordinate at a time (S_ACC_MUL, S_ACC_ADD).
// Each cluster output needs up to 16 divisions on the shared divider. One
// result beat (m_*) leaves per cluster, at most 32 per frame, the last with
// final_result set; an empty frame gives a single beat with none_found set.
// s_ready is high only while the block is idle. A stalled result beat holds
// the sequencer until it is taken. Reset empties the store at once and sets
// overlap_threshold (apb, address 0) back to its default.
module weighted_box_suppression_top #(
    parameter int MAX_DETS   = 32,
    parameter int NUM_POINTS = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  wbs_pkg::in_item_t                 s_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output wbs_pkg::out_item_t                m_item,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wbs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import wbs_pkg::*;

    localparam int IW = $clog2(MAX_DETS);
    localparam int CW = $clog2(MAX_DETS + 1);
    localparam int EW = $bits(entry_t);

    typedef enum logic [23:0] {
        S_IDLE      = 24'h000001,
        S_INS_CHK   = 24'h000002,
        S_INS_FULL  = 24'h000004,
        S_INS_STEP  = 24'h000008,
        S_INS_CMP   = 24'h000010,
        S_INS_DONE  = 24'h000020,
        S_FR_START  = 24'h000040,
        S_LEAD_SCAN = 24'h000080,
        S_LEAD_LOAD = 24'h000100,
        S_ACC_MUL   = 24'h000200,
        S_ACC_ADD   = 24'h000400,
        S_LAREA_MUL = 24'h000800,
        S_LAREA_GET = 24'h001000,
        S_CAND_SCAN = 24'h002000,
        S_CAND_LOAD = 24'h004000,
        S_IOU_INTER = 24'h008000,
        S_IOU_AREA  = 24'h010000,
        S_IOU_UNI   = 24'h020000,
        S_IOU_CMP   = 24'h040000,
        S_DIV_START = 24'h080000,
        S_DIV_WAIT  = 24'h100000,
        S_EMIT      = 24'h200000,
        S_OUT       = 24'h400000,
        S_FR_END    = 24'h800000
    } state_t;

    function automatic logic coord_used(input logic [3:0] c);
        logic [3:0] cm;
        cm = c - 4'd4;
        return (c < 4'd4) || (int'(cm[3:1]) < NUM_POINTS);
    endfunction

    state_t              state_reg, state_next;
    in_item_t            in_reg, in_next;
    logic [15:0]         thr_reg, thr_next;
    logic [CW-1:0]       held_reg, held_next;
    logic                ovf_reg, ovf_next;
    logic [MAX_DETS-1:0] supp_reg, supp_next;
    logic [IW-1:0]       k_reg, k_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [RES_CNT_W-1:0] n_reg, n_next;
    logic [3:0]          c_reg, c_next;
    logic                ret_lead_reg, ret_lead_next;
    entry_t              lead_reg, lead_next;
    entry_t              mem_reg, mem_next;
    logic [31:0]         area_a_reg, area_a_next;
    logic [31:0]         inter_reg, inter_next;
    logic [SUM_W-1:0]    sums_reg [NUM_COORDS];
    logic [SUM_W-1:0]    sums_next [NUM_COORDS];
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [15:0]         res_reg [NUM_COORDS];
    logic [15:0]         res_next [NUM_COORDS];
    out_item_t           out_reg, out_next;

    logic                ram_we, ram_re;
    logic [IW-1:0]       ram_waddr, ram_raddr;
    entry_t              ram_wdata, ram_rdata;
    logic [EW-1:0]       ram_rdata_raw;

    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PROD_W-1:0]   prod;

    logic                div_start, div_done;
    logic [15:0]         div_q;

    entry_t              new_entry;
    logic [15:0]         iw, ih, lw, lh, mw, mh;
    logic [MUL_B_W-1:0]  uni;
    logic [MAX_DETS-1:0] remain;
    logic                cfg_wr;

    wbs_ram #(.WIDTH(EW), .DEPTH(MAX_DETS)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );
    assign ram_rdata = entry_t'(ram_rdata_raw);

    wbs_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    wbs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sums_reg[c_reg]),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // apb register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == REG_THRESH);
    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_THRESH) ? {16'd0, thr_reg} : 32'd0;

    assign new_entry = '{box:   {in_reg.box_bottom, in_reg.box_right, in_reg.box_top,
                                 in_reg.box_left},
                         score: in_reg.confidence,
                         pts_a: in_reg.points_a,
                         pts_b: in_reg.points_b,
                         pts_c: in_reg.points_c};

    // box geometry between leader and candidate
    always_comb begin
        lw = span(fld(lead_reg.box, 2'd0), fld(lead_reg.box, 2'd2));
        lh = span(fld(lead_reg.box, 2'd1), fld(lead_reg.box, 2'd3));
        mw = span(fld(mem_reg.box, 2'd0), fld(mem_reg.box, 2'd2));
        mh = span(fld(mem_reg.box, 2'd1), fld(mem_reg.box, 2'd3));
        iw = span(max16(fld(lead_reg.box, 2'd0), fld(mem_reg.box, 2'd0)),
                  min16(fld(lead_reg.box, 2'd2), fld(mem_reg.box, 2'd2)));
        ih = span(max16(fld(lead_reg.box, 2'd1), fld(mem_reg.box, 2'd1)),
                  min16(fld(lead_reg.box, 2'd3), fld(mem_reg.box, 2'd3)));
        uni = {2'b0, area_a_reg} + {2'b0, prod[31:0]} - {2'b0, inter_reg} + EPS_Q32;
    end

    // entries after the current leader still waiting for a cluster
    always_comb begin
        for (int e = 0; e < MAX_DETS; e++) begin
            remain[e] = !supp_reg[e] && (CW'(e) > i_reg) && (CW'(e) < held_reg);
        end
    end

    always_comb begin
        state_next    = state_reg;
        in_next       = in_reg;
        thr_next      = cfg_wr ? pwdata[15:0] : thr_reg;
        held_next     = held_reg;
        ovf_next      = ovf_reg;
        supp_next     = supp_reg;
        k_next        = k_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        n_next        = n_reg;
        c_next        = c_reg;
        ret_lead_next = ret_lead_reg;
        lead_next     = lead_reg;
        mem_next      = mem_reg;
        area_a_next   = area_a_reg;
        inter_next    = inter_reg;
        sums_next     = sums_reg;
        total_next    = total_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        ram_we        = 1'b0;
        ram_waddr     = k_reg;
        ram_wdata     = new_entry;
        ram_re        = 1'b0;
        ram_raddr     = k_reg - IW'(1);
        mul_a         = iw;
        mul_b         = {18'd0, ih};
        div_start     = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    in_next = s_item;
                    if (s_item.valid_req) begin
                        state_next = S_INS_CHK;
                    end else if (s_item.frame_end) begin
                        state_next = S_FR_START;
                    end
                end
            end
            S_INS_CHK: begin
                if (held_reg == CW'(MAX_DETS)) begin
                    ram_re     = 1'b1;
                    ram_raddr  = IW'(MAX_DETS - 1);
                    state_next = S_INS_FULL;
                end else begin
                    k_next     = held_reg[IW-1:0];
                    state_next = S_INS_STEP;
                end
            end
            S_INS_FULL: begin
                ovf_next = 1'b1;
                // newcomer ranks last: drop it
                if (ram_rdata.score >= in_reg.confidence) begin
                    state_next = S_INS_DONE;
                end else begin
                    k_next     = IW'(MAX_DETS - 1);
                    state_next = S_INS_STEP;
                end
            end
            S_INS_STEP: begin
                if (k_reg == '0) begin
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                    if (held_reg != CW'(MAX_DETS)) begin
                        held_next = held_reg + CW'(1);
                    end
                    state_next = S_INS_DONE;
                end else begin
                    ram_re     = 1'b1;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                ram_we = 1'b1;
                if (ram_rdata.score < in_reg.confidence) begin
                    ram_wdata  = ram_rdata;
                    k_next     = k_reg - IW'(1);
                    state_next = S_INS_STEP;
                end else begin
                    if (held_reg != CW'(MAX_DETS)) begin
                        held_next = held_reg + CW'(1);
                    end
                    state_next = S_INS_DONE;
                end
            end
            S_INS_DONE: begin
                state_next = in_reg.frame_end ? S_FR_START : S_IDLE;
            end
            S_FR_START: begin
                if (held_reg == '0) begin
                    out_next              = '0;
                    out_next.none_found   = 1'b1;
                    out_next.final_result = 1'b1;
                    state_next            = S_OUT;
                end else begin
                    i_next     = '0;
                    n_next     = '0;
                    state_next = S_LEAD_SCAN;
                end
            end
            S_LEAD_SCAN: begin
                if (i_reg >= held_reg) begin
                    state_next = S_FR_END;
                end else if (supp_reg[i_reg[IW-1:0]]) begin
                    i_next = i_reg + CW'(1);
                end else begin
                    supp_next[i_reg[IW-1:0]] = 1'b1;
                    ram_re     = 1'b1;
                    ram_raddr  = i_reg[IW-1:0];
                    state_next = S_LEAD_LOAD;
                end
            end
            S_LEAD_LOAD: begin
                lead_next     = ram_rdata;
                mem_next      = ram_rdata;
                for (int c = 0; c < NUM_COORDS; c++) begin
                    sums_next[c] = '0;
                end
                total_next    = '0;
                c_next        = '0;
                ret_lead_next = 1'b1;
                state_next    = S_ACC_MUL;
            end
            S_ACC_MUL: begin
                mul_a      = coord_of(mem_reg, c_reg);
                mul_b      = {18'd0, mem_reg.score};
                state_next = S_ACC_ADD;
            end
            S_ACC_ADD: begin
                sums_next[c_reg] = sums_reg[c_reg] + prod[SUM_W-1:0];
                if (c_reg == 4'd15) begin
                    total_next = total_reg + TOTAL_W'(mem_reg.score);
                    if (ret_lead_reg) begin
                        state_next = S_LAREA_MUL;
                    end else begin
                        j_next     = j_reg + CW'(1);
                        state_next = S_CAND_SCAN;
                    end
                end else begin
                    c_next     = c_reg + 4'd1;
                    state_next = S_ACC_MUL;
                end
            end
            S_LAREA_MUL: begin
                mul_a      = lw;
                mul_b      = {18'd0, lh};
                state_next = S_LAREA_GET;
            end
            S_LAREA_GET: begin
                area_a_next = prod[31:0];
                j_next      = i_reg + CW'(1);
                state_next  = S_CAND_SCAN;
            end
            S_CAND_SCAN: begin
                if (j_reg >= held_reg) begin
                    c_next     = '0;
                    state_next = S_DIV_START;
                end else if (supp_reg[j_reg[IW-1:0]]) begin
                    j_next = j_reg + CW'(1);
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = j_reg[IW-1:0];
                    state_next = S_CAND_LOAD;
                end
            end
            S_CAND_LOAD: begin
                mem_next   = ram_rdata;
                state_next = S_IOU_INTER;
            end
            S_IOU_INTER: begin
                mul_a      = iw;
                mul_b      = {18'd0, ih};
                state_next = S_IOU_AREA;
            end
            S_IOU_AREA: begin
                inter_next = prod[31:0];
                mul_a      = mw;
                mul_b      = {18'd0, mh};
                state_next = S_IOU_UNI;
            end
            S_IOU_UNI: begin
                mul_a      = thr_reg;
                mul_b      = uni;
                state_next = S_IOU_CMP;
            end
            S_IOU_CMP: begin
                // inter * 2^16 against threshold * (union + eps)
                if ({2'b0, inter_reg, 16'd0} > prod) begin
                    supp_next[j_reg[IW-1:0]] = 1'b1;
                    ret_lead_next = 1'b0;
                    c_next        = '0;
                    state_next    = S_ACC_MUL;
                end else begin
                    j_next     = j_reg + CW'(1);
                    state_next = S_CAND_SCAN;
                end
            end
            S_DIV_START: begin
                if (!coord_used(c_reg) || (total_reg == '0)) begin
                    res_next[c_reg] = coord_used(c_reg) ? coord_of(lead_reg, c_reg) : 16'd0;
                    if (c_reg == 4'd15) begin
                        state_next = S_EMIT;
                    end else begin
                        c_next = c_reg + 4'd1;
                    end
                end else begin
                    div_start  = 1'b1;
                    state_next = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    res_next[c_reg] = div_q;
                    if (c_reg == 4'd15) begin
                        state_next = S_EMIT;
                    end else begin
                        c_next     = c_reg + 4'd1;
                        state_next = S_DIV_START;
                    end
                end
            end
            S_EMIT: begin
                out_next.merged_left     = res_reg[0];
                out_next.merged_top      = res_reg[1];
                out_next.merged_right    = res_reg[2];
                out_next.merged_bottom   = res_reg[3];
                out_next.lead_score      = lead_reg.score;
                out_next.merged_points_a = {res_reg[7], res_reg[6], res_reg[5], res_reg[4]};
                out_next.merged_points_b = {res_reg[11], res_reg[10], res_reg[9], res_reg[8]};
                out_next.merged_points_c = {res_reg[15], res_reg[14], res_reg[13], res_reg[12]};
                out_next.overflowed      = ovf_reg;
                out_next.none_found      = 1'b0;
                out_next.final_result    = (n_reg == RES_CNT_W'(RESULT_LIMIT - 1)) || !(|remain);
                state_next               = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    if (out_reg.final_result) begin
                        state_next = S_FR_END;
                    end else begin
                        i_next     = i_reg + CW'(1);
                        n_next     = n_reg + RES_CNT_W'(1);
                        state_next = S_LEAD_SCAN;
                    end
                end
            end
            S_FR_END: begin
                held_next  = '0;
                ovf_next   = 1'b0;
                supp_next  = '0;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            thr_reg   <= THRESH_RESET;
            held_reg  <= '0;
            ovf_reg   <= 1'b0;
            supp_reg  <= '0;
        end else begin
            state_reg <= state_next;
            thr_reg   <= thr_next;
            held_reg  <= held_next;
            ovf_reg   <= ovf_next;
            supp_reg  <= supp_next;
        end
        in_reg       <= in_next;
        k_reg        <= k_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        n_reg        <= n_next;
        c_reg        <= c_next;
        ret_lead_reg <= ret_lead_next;
        lead_reg     <= lead_next;
        mem_reg      <= mem_next;
        area_a_reg   <= area_a_next;
        inter_reg    <= inter_next;
        sums_reg     <= sums_next;
        total_reg    <= total_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_item  = out_reg;
endmodule

// ===== hw/rtl/wbs_checker.sv =====
// port-level checks for the weighted box suppression block, bound to the top
// depends on wbs_pkg and assert_macros.svh
`include "assert_macros.svh"

module wbs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input wbs_pkg::in_item_t              s_item,
    input logic                           m_valid,
    input logic                           m_ready,
    input wbs_pkg::out_item_t             m_item
);
    import wbs_pkg::*;

    // a stalled result beat holds
    `WBS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_item))
    // the block never takes input while a result is pending
    `WBS_ASSERT_IMPL(a_one_side, aclk, aresetn, m_valid, !s_ready)
    // a none_found beat is final, with zero lead score, left edge and points_a
    `WBS_ASSERT_IMPL(a_empty_frame, aclk, aresetn, m_valid && m_item.none_found,
        m_item.final_result && (m_item.lead_score == 16'd0) &&
        (m_item.merged_left == 16'd0) && (m_item.merged_points_a == 64'd0))
    // a closing beat leaves the block busy for the suppression pass
    `WBS_ASSERT_NEXT(a_frame_busy, aclk, aresetn,
        s_valid && s_ready && s_item.frame_end, !s_ready)
endmodule

bind weighted_box_suppression_top wbs_checker u_wbs_checker (.*);

// ===== dv/tb_weighted_box_suppression_top.sv =====
// testbench for weighted_box_suppression_top: drives detection frames, predicts clusters
// depends on wbs_pkg and weighted_box_suppression_top
`timescale 1ns / 1ps

module tb_weighted_box_suppression_top;
    import wbs_pkg::*;

    localparam int CAP      = 32;
    localparam int NPTS     = 6;
    localparam int MAX_CYC  = 3000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_item = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    weighted_box_suppression_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic [15:0] iou_thresh;
    entry_t      held[CAP];
    int          held_n;
    logic        dropped;
    out_item_t   cluster_q[$];

    int  errors;
    int  cycles;
    int  results_seen;
    int  frames_sent;
    bit  hold_off;

    function automatic logic [15:0] pick(entry_t e, int c);
        int k;
        k = c - 4;
        if (c < 4) return e.box[16*c +: 16];
        case (k / 4)
            0: return e.pts_a[16*(k%4) +: 16];
            1: return e.pts_b[16*(k%4) +: 16];
            default: return e.pts_c[16*(k%4) +: 16];
        endcase
    endfunction

    function automatic longint unsigned width_of(logic [15:0] lo, logic [15:0] hi);
        return hi > lo ? longint'(hi - lo) : 0;
    endfunction

    function automatic bit boxes_merge(entry_t a, entry_t b);
        longint unsigned inter, ua, ub, uni, lhs, rhs;
        logic [15:0] il, it, ir, ib;
        il = a.box[15:0] > b.box[15:0] ? a.box[15:0] : b.box[15:0];
        it = a.box[31:16] > b.box[31:16] ? a.box[31:16] : b.box[31:16];
        ir = a.box[47:32] < b.box[47:32] ? a.box[47:32] : b.box[47:32];
        ib = a.box[63:48] < b.box[63:48] ? a.box[63:48] : b.box[63:48];
        inter = width_of(il, ir) * width_of(it, ib);
        ua = width_of(a.box[15:0], a.box[47:32]) * width_of(a.box[31:16], a.box[63:48]);
        ub = width_of(b.box[15:0], b.box[47:32]) * width_of(b.box[31:16], b.box[63:48]);
        uni = ua + ub - inter;
        lhs = inter << 16;
        rhs = longint'(iou_thresh) * (uni + 4295);
        return lhs > rhs;
    endfunction

    function automatic void store_detection(in_item_t it);
        entry_t e;
        int pos, last;
        e.box = {it.box_bottom, it.box_right, it.box_top, it.box_left};
        e.score = it.confidence;
        e.pts_a = it.points_a;
        e.pts_b = it.points_b;
        e.pts_c = it.points_c;
        pos = held_n;
        while (pos > 0 && held[pos-1].score < e.score) pos--;
        if (held_n >= CAP) begin
            dropped = 1'b1;
            if (pos >= CAP) return;
            last = CAP - 1;
        end else begin
            last = held_n;
            held_n++;
        end
        for (int k = last; k > pos; k--) held[k] = held[k-1];
        held[pos] = e;
    endfunction

    function automatic void queue_cluster(out_item_t r);
        cluster_q = {cluster_q, r};
    endfunction

    function automatic void predict_frame(in_item_t it);
        bit sup[CAP];
        longint unsigned sums[16];
        longint unsigned tot, v;
        out_item_t r;
        int n;
        if (it.valid_req) store_detection(it);
        if (!it.frame_end) return;
        n = 0;
        if (held_n == 0) begin
            r = '0;
            r.none_found = 1'b1;
            r.final_result = 1'b1;
            queue_cluster(r);
        end else begin
            for (int i = 0; i < CAP; i++) sup[i] = 0;
            for (int i = 0; i < held_n && n < RESULT_LIMIT; i++) begin
                if (sup[i]) continue;
                sup[i] = 1;
                for (int c = 0; c < 16; c++) sums[c] = pick(held[i], c) * held[i].score;
                tot = held[i].score;
                for (int j = i + 1; j < held_n; j++) begin
                    if (!sup[j] && boxes_merge(held[i], held[j])) begin
                        for (int c = 0; c < 16; c++)
                            sums[c] += pick(held[j], c) * held[j].score;
                        tot += held[j].score;
                        sup[j] = 1;
                    end
                end
                r = '0;
                for (int c = 0; c < 16; c++) begin
                    if (c >= 4 && (c - 4) / 2 >= NPTS) continue;
                    v = tot != 0 ? sums[c] / tot : pick(held[i], c);
                    case (c)
                        0: r.merged_left = v[15:0];
                        1: r.merged_top = v[15:0];
                        2: r.merged_right = v[15:0];
                        3: r.merged_bottom = v[15:0];
                        default: begin
                            if (c < 8) r.merged_points_a[16*(c-4) +: 16] = v[15:0];
                            else if (c < 12) r.merged_points_b[16*(c-8) +: 16] = v[15:0];
                            else r.merged_points_c[16*(c-12) +: 16] = v[15:0];
                        end
                    endcase
                end
                r.lead_score = held[i].score;
                r.overflowed = dropped;
                queue_cluster(r);
                n++;
            end
            cluster_q[cluster_q.size()-1].final_result = 1'b1;
        end
        held_n = 0;
        dropped = 1'b0;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYC) begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        int w;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_off = 0;
            end
            w = $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0) w = 0;
            if (w > 0) begin
                m_ready <= 1'b0;
                repeat (w - 1) @(posedge aclk);
                @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            m_ready <= 1'b0;
        end
    end

    // checks each result beat against the oldest predicted cluster
    always @(posedge aclk) begin
        out_item_t w;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (cluster_q.size() == 0) begin
                report("unexpected beat", m_item.lead_score, 0);
            end else begin
                w = cluster_q.pop_front();
                if (m_item.merged_left !== w.merged_left)
                    report("merged_left", m_item.merged_left, w.merged_left);
                if (m_item.merged_top !== w.merged_top)
                    report("merged_top", m_item.merged_top, w.merged_top);
                if (m_item.merged_right !== w.merged_right)
                    report("merged_right", m_item.merged_right, w.merged_right);
                if (m_item.merged_bottom !== w.merged_bottom)
                    report("merged_bottom", m_item.merged_bottom, w.merged_bottom);
                if (m_item.lead_score !== w.lead_score)
                    report("lead_score", m_item.lead_score, w.lead_score);
                if (m_item.merged_points_a !== w.merged_points_a)
                    report("merged_points_a", m_item.merged_points_a, w.merged_points_a);
                if (m_item.merged_points_b !== w.merged_points_b)
                    report("merged_points_b", m_item.merged_points_b, w.merged_points_b);
                if (m_item.merged_points_c !== w.merged_points_c)
                    report("merged_points_c", m_item.merged_points_c, w.merged_points_c);
                if (m_item.overflowed !== w.overflowed)
                    report("overflowed", m_item.overflowed, w.overflowed);
                if (m_item.none_found !== w.none_found)
                    report("none_found", m_item.none_found, w.none_found);
                if (m_item.final_result !== w.final_result)
                    report("final_result", m_item.final_result, w.final_result);
            end
        end
    end

    task automatic send_detection(in_item_t it, bit no_gap = 0);
        int w;
        w = no_gap ? 0 : $urandom_range(0, 3);
        repeat (w) @(posedge aclk);
        predict_frame(it);
        s_item <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
        s_valid <= 1'b0;
        // the block is busy after every beat that carries a detection or closes the frame
        @(posedge aclk);
        if (it.frame_end) frames_sent++;
    endtask

    task automatic wait_drained();
        while (cluster_q.size() != 0) @(posedge aclk);
        repeat (1200) @(posedge aclk);
    endtask

    task automatic write_thresh(logic [15:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(REG_THRESH) << 2; pwdata <= {16'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        iou_thresh = val;
    endtask

    function automatic in_item_t rand_det(bit close_frame, int spread);
        in_item_t it;
        logic [15:0] x, y, cx, cy;
        it.valid_req = 1'b1;
        cx = 16'($urandom_range(0, spread));
        cy = 16'($urandom_range(0, spread));
        x = 16'($urandom_range(1000, 20000));
        y = 16'($urandom_range(1000, 20000));
        it.box_left = cx + 16'($urandom_range(0, 1500));
        it.box_top = cy + 16'($urandom_range(0, 1500));
        it.box_right = it.box_left + x;
        it.box_bottom = it.box_top + y;
        if ($urandom_range(0, 9) == 0) begin
            it.box_left = 16'($urandom); it.box_right = 16'($urandom);
            it.box_top = 16'($urandom); it.box_bottom = 16'($urandom);
        end
        it.confidence = $urandom_range(0, 7) == 0 ? 16'($urandom_range(0, 3))
                                                 : 16'($urandom);
        it.points_a = {$urandom, $urandom};
        it.points_b = {$urandom, $urandom};
        it.points_c = {$urandom, $urandom};
        it.frame_end = close_frame;
        return it;
    endfunction

    task automatic test_directed();
        in_item_t it;
        // empty frame
        it = '0; it.frame_end = 1'b1;
        send_detection(it);
        // extremes in one frame, plus a duplicate with equal score
        it = '1; it.frame_end = 1'b0;
        send_detection(it);
        it = '0; it.valid_req = 1'b1;
        send_detection(it);
        it = rand_det(0, 2000); it.confidence = 16'h8000;
        send_detection(it);
        it.points_a = ~it.points_a;
        send_detection(it);
        it = rand_det(0, 2000); it.box_right = 16'd0; it.box_bottom = 16'd0;
        send_detection(it);
        // empty closing beat on a non-empty frame
        it = '0; it.frame_end = 1'b1;
        send_detection(it);
        wait_drained();
        // zero-score cluster falls back to the leader coordinates
        it = rand_det(0, 100); it.confidence = 16'd0;
        send_detection(it);
        it.frame_end = 1'b1;
        send_detection(it);
        wait_drained();
    endtask

    task automatic test_thresholds();
        logic [15:0] th[3] = '{16'd0, 16'hffff, 16'd30000};
        foreach (th[k]) begin
            write_thresh(th[k]);
            for (int i = 0; i < 6; i++) send_detection(rand_det(i == 5, 6000));
            wait_drained();
        end
        write_thresh(THRESH_RESET);
    endtask

    task automatic test_overflow();
        in_item_t it;
        // more candidates than the store holds, with ties at the bottom
        for (int i = 0; i < CAP + 6; i++) begin
            it = rand_det(i == CAP + 5, 40000);
            if (i >= CAP) it.confidence = 16'd0;
            send_detection(it);
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_off = 1;
        for (int i = 0; i < 12; i++) send_detection(rand_det(i % 6 == 5, 3000), 1);
        wait_drained();
    endtask

    task automatic test_random_frames();
        int left, len;
        left = 110;
        while (left > 0) begin
            len = $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : $urandom_range(3, 12);
            if (len > left) len = left;
            for (int i = 0; i < len; i++) send_detection(rand_det(i == len - 1,
                $urandom_range(0, 1) ? 4000 : 50000));
            left -= len;
            if ($urandom_range(0, 3) == 0) begin
                while (cluster_q.size() != 0) @(posedge aclk);
            end
        end
        wait_drained();
    endtask

    initial begin
        errors = 0; cycles = 0; results_seen = 0; frames_sent = 0; hold_off = 0;
        held_n = 0; dropped = 1'b0; iou_thresh = THRESH_RESET;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_thresholds();
        test_overflow();
        test_backpressure();
        test_random_frames();
        $display("covered %0d frames and %0d result beats, with overflow, empty frames",
                 frames_sent, results_seen);
        $display("and thresholds at both ends");
        if (errors == 0 && cluster_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
